// ----- sv/tttd_pkg.sv -----
// ----------------------------------------------------------------------------
// tttd_pkg
// Types, constants and codes of the time-triggered task dispatcher.
// ----------------------------------------------------------------------------
package tttd_pkg;

   localparam int MaxTasks = 8;
   localparam int SlotW = 3;
   localparam int CountW = 4;

   localparam logic [1:0] ModeCreate = 2'd0;
   localparam logic [1:0] ModeTick = 2'd1;
   localparam logic [1:0] ModeDone = 2'd2;

   localparam logic [2:0] KindCreated = 3'd0;
   localparam logic [2:0] KindFull = 3'd1;
   localparam logic [2:0] KindRun = 3'd2;
   localparam logic [2:0] KindNone = 3'd3;
   localparam logic [2:0] KindStats = 3'd4;

   localparam logic [7:0] StopStatus = 8'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [15:0] period_mask;
      logic [15:0] phase;
      logic [7:0] priority_req;
      logic [15:0] slice_number;
      logic [2:0] task_index;
      logic [7:0] run_status;
      logic [31:0] start_time;
      logic [31:0] end_time;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] slot;
      logic last;
      logic [31:0] elapsed;
      logic [31:0] max_elapsed;
      logic [31:0] run_count;
      logic [31:0] total_runtime;
   } rsp_type;

   typedef struct packed {
      logic [15:0] mask;
      logic [15:0] phase;
      logic [7:0] prio;
      logic [7:0] status;
      logic [2:0] slot;
      logic live;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic done;
      logic [2:0] task_index;
      logic [7:0] run_status;
   } cmd_type;

endpackage

// ----- sv/tttd_cell.sv -----
// ----------------------------------------------------------------------------
// tttd_cell
// One place of the priority-ordered task chain. On a create each cell decides
// whether to keep its task, take the new one or take its upper neighbor's.
// During a scan the chain rotates by one place each cycle towards cell zero.
// ----------------------------------------------------------------------------
module tttd_cell (
   input logic clock,
   input logic reset,
   input tttd_pkg::cmd_type cmd,
   input tttd_pkg::entry_type new_entry,
   input tttd_pkg::entry_type prev_entry,
   input logic prev_goes_down,
   input tttd_pkg::entry_type next_entry,
   output tttd_pkg::entry_type entry,
   output logic goes_down
);
   import tttd_pkg::*;

   entry_type entry_ff, entry_in;

   assign entry = entry_ff;
   assign goes_down = !entry_ff.live || (new_entry.prio >= entry_ff.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (goes_down) begin
            entry_in = prev_goes_down ? prev_entry : new_entry;
         end
      end else if (cmd.shift) begin
         entry_in = next_entry;
      end else if (cmd.done && entry_ff.live && entry_ff.slot == cmd.task_index) begin
         entry_in.status = cmd.run_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.live <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ----- sv/time_triggered_task_dispatcher_unit.sv -----
// ----------------------------------------------------------------------------
// time_triggered_task_dispatcher_unit
// Time-triggered task table built as a chain of cells ordered by priority.
//
// A request is taken when start is high and busy is low. A create answers in
// the next cycle with created or table full. A done request answers through
// the S_DONE state with the task statistics, or with nothing for an unknown
// slot. A tick rotates the chain once around, checking the task at the head
// each cycle, and emits one run result per due task, or one none due result.
// Each result is on rsp_data for one cycle with rsp_valid high; rsp_data.last
// marks the final one. The receiver cannot stall. Reset empties the table.
// ----------------------------------------------------------------------------
module time_triggered_task_dispatcher_unit (
   input logic clock,
   input logic reset,
   input logic start,
   input tttd_pkg::req_type req_data,
   output logic busy,
   output logic rsp_valid,
   output tttd_pkg::rsp_type rsp_data
);
   import tttd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DONE = 4'b0100,
      S_END = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW-1:0] step_ff, step_in;
   logic any_ff, any_in;
   logic pend_ff, pend_in;
   logic [2:0] pend_slot_ff, pend_slot_in;
   logic [15:0] slice_ff, slice_in;
   req_type req_ff, req_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic [31:0] cnt_mem [MaxTasks];
   logic [31:0] tot_mem [MaxTasks];
   logic [31:0] max_mem [MaxTasks];
   logic [31:0] elapsed;

   cmd_type cmd;
   entry_type new_entry;
   entry_type ents [MaxTasks];
   logic downs [MaxTasks];
   logic accept;
   logic head_due;

   assign accept = start && (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      new_entry.mask = (req_data.period_mask == 16'd0) ? 16'd1 : req_data.period_mask;
      new_entry.phase = req_data.phase;
      new_entry.prio = req_data.priority_req;
      new_entry.status = 8'd0;
      new_entry.slot = count_ff[SlotW-1:0];
      new_entry.live = 1'b1;
      cmd.insert = accept && req_data.mode == ModeCreate && count_ff < CountW'(MaxTasks);
      cmd.shift = (state_ff == S_SCAN);
      cmd.done = accept && req_data.mode == ModeDone
         && {1'b0, req_data.task_index} < count_ff;
      cmd.task_index = req_data.task_index;
      cmd.run_status = req_data.run_status;
   end

   for (genvar g = 0; g < MaxTasks; g++) begin : g_cell
      tttd_cell u_cell (
         .clock(clock),
         .reset(reset),
         .cmd(cmd),
         .new_entry(new_entry),
         .prev_entry((g == 0) ? new_entry : ents[(g == 0) ? 0 : g-1]),
         .prev_goes_down((g == 0) ? 1'b0 : downs[(g == 0) ? 0 : g-1]),
         .next_entry(ents[(g + 1) % MaxTasks]),
         .entry(ents[g]),
         .goes_down(downs[g])
      );
   end

   assign head_due = ents[0].live && ents[0].status < StopStatus
      && ((slice_ff & ents[0].mask) == ents[0].phase);
   assign elapsed = req_ff.end_time - req_ff.start_time;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in = step_ff;
      any_in = any_ff;
      pend_in = pend_ff;
      pend_slot_in = pend_slot_ff;
      slice_in = slice_ff;
      req_in = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               slice_in = req_data.slice_number;
               case (req_data.mode)
                  ModeCreate: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.last = 1'b1;
                     if (cmd.insert) begin
                        rsp_in.kind = KindCreated;
                        rsp_in.slot = count_ff[SlotW-1:0];
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_in.kind = KindFull;
                     end
                  end
                  ModeTick: begin
                     state_in = S_SCAN;
                     step_in = '0;
                     any_in = 1'b0;
                     pend_in = 1'b0;
                  end
                  ModeDone: begin
                     if (cmd.done) begin
                        state_in = S_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (head_due) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind = KindRun;
                  rsp_in.slot = pend_slot_ff;
               end
               pend_in = 1'b1;
               pend_slot_in = ents[0].slot;
               any_in = 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == CountW'(MaxTasks - 1)) begin
               state_in = S_END;
            end
         end
         S_END: begin
            rsp_valid_in = 1'b1;
            rsp_in.last = 1'b1;
            if (any_ff) begin
               rsp_in.kind = KindRun;
               rsp_in.slot = pend_slot_ff;
            end else begin
               rsp_in.kind = KindNone;
            end
            state_in = S_IDLE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.kind = KindStats;
            rsp_in.slot = req_ff.task_index;
            rsp_in.last = 1'b1;
            rsp_in.elapsed = elapsed;
            rsp_in.run_count = cnt_mem[req_ff.task_index] + 32'd1;
            rsp_in.total_runtime = tot_mem[req_ff.task_index] + elapsed;
            rsp_in.max_elapsed = (elapsed > max_mem[req_ff.task_index])
               ? elapsed : max_mem[req_ff.task_index];
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      any_ff <= any_in;
      pend_ff <= pend_in;
      pend_slot_ff <= pend_slot_in;
      slice_ff <= slice_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (cmd.insert) begin
         cnt_mem[count_ff[SlotW-1:0]] <= '0;
         tot_mem[count_ff[SlotW-1:0]] <= '0;
         max_mem[count_ff[SlotW-1:0]] <= '0;
      end
      if (state_ff == S_DONE) begin
         cnt_mem[req_ff.task_index] <= rsp_in.run_count;
         tot_mem[req_ff.task_index] <= rsp_in.total_runtime;
         max_mem[req_ff.task_index] <= rsp_in.max_elapsed;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxTasks)) else $error("task count overflow");
   a_full_no_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode == ModeCreate && count_ff == CountW'(MaxTasks))
      |=> $stable(count_ff)) else $error("full table grew");
   a_busy_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> !(rsp_valid && rsp_data.kind == KindRun && !rsp_data.last)
      || $past(state_ff) != S_IDLE) else $error("run result outside scan");

endmodule

// ----- sim/time_triggered_task_dispatcher_unit_checker.sv -----
// ----------------------------------------------------------------------------
// time_triggered_task_dispatcher_unit_checker
// Watches the request and response channels of the task dispatcher, keeps its
// own copy of the task table, predicts every response and compares them.
// ----------------------------------------------------------------------------
module time_triggered_task_dispatcher_unit_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input tttd_pkg::req_type req_data,
   input logic rsp_valid,
   input tttd_pkg::rsp_type rsp_data,
   output int fail_count,
   output int pending_count,
   output int created_count,
   output int stats_count
);
   import tttd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type expected_rsps[$];

   int unsigned live_tasks;
   logic [2:0] order_list[MaxTasks];
   logic [15:0] mask_tab[MaxTasks];
   logic [15:0] phase_tab[MaxTasks];
   logic [7:0] prio_tab[MaxTasks];
   logic [7:0] status_tab[MaxTasks];
   logic [31:0] count_tab[MaxTasks];
   logic [31:0] runtime_tab[MaxTasks];
   logic [31:0] max_tab[MaxTasks];

   function automatic rsp_type make_rsp(logic [2:0] kind, logic [2:0] slot, logic last);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.slot = slot;
      r.last = last;
      return r;
   endfunction

   task automatic dispatch_request(req_type rq);
      int unsigned pos;
      int unsigned s;
      int n;
      logic [15:0] m;
      logic [31:0] el;
      rsp_type r;
      case (rq.mode)
         ModeCreate: begin
            if (live_tasks >= MaxTasks) begin
               expected_rsps.push_back(make_rsp(KindFull, 3'd0, 1'b1));
            end else begin
               s = live_tasks;
               m = (rq.period_mask == 16'd0) ? 16'd1 : rq.period_mask;
               mask_tab[s] = m;
               phase_tab[s] = rq.phase;
               prio_tab[s] = rq.priority_req;
               status_tab[s] = '0;
               count_tab[s] = '0;
               runtime_tab[s] = '0;
               max_tab[s] = '0;
               pos = 0;
               while (pos < live_tasks && rq.priority_req < prio_tab[order_list[pos]])
                  pos++;
               for (int i = live_tasks; i > pos; i--)
                  order_list[i] = order_list[i-1];
               order_list[pos] = s[2:0];
               live_tasks++;
               expected_rsps.push_back(make_rsp(KindCreated, s[2:0], 1'b1));
            end
         end
         ModeTick: begin
            n = 0;
            for (int i = 0; i < live_tasks; i++) begin
               s = order_list[i];
               if (((rq.slice_number & mask_tab[s]) == phase_tab[s])
                   && status_tab[s] < StopStatus) begin
                  expected_rsps.push_back(make_rsp(KindRun, s[2:0], 1'b0));
                  n++;
               end
            end
            if (n == 0) begin
               expected_rsps.push_back(make_rsp(KindNone, 3'd0, 1'b1));
            end else begin
               r = expected_rsps.pop_back();
               r.last = 1'b1;
               expected_rsps.push_back(r);
            end
         end
         ModeDone: begin
            s = rq.task_index;
            if (s < live_tasks) begin
               el = rq.end_time - rq.start_time;
               status_tab[s] = rq.run_status;
               count_tab[s] = count_tab[s] + 32'd1;
               runtime_tab[s] = runtime_tab[s] + el;
               if (el > max_tab[s])
                  max_tab[s] = el;
               r = make_rsp(KindStats, s[2:0], 1'b1);
               r.elapsed = el;
               r.max_elapsed = max_tab[s];
               r.run_count = count_tab[s];
               r.total_runtime = runtime_tab[s];
               expected_rsps.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         live_tasks = 0;
         expected_rsps.delete();
         fail_count = 0;
         created_count = 0;
         stats_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
                  fail_count++;
               end
               if (want.kind == KindCreated)
                  created_count++;
               if (want.kind == KindStats)
                  stats_count++;
            end
         end
         if (start && !busy)
            dispatch_request(req_data);
      end
      pending_count = expected_rsps.size();
   end

endmodule

// ----- sim/time_triggered_task_dispatcher_unit_tb.sv -----
// ----------------------------------------------------------------------------
// time_triggered_task_dispatcher_unit_tb
// Drives create, tick and done requests with random gaps into the task
// dispatcher, including creates into a full table, with no reset between.
// ----------------------------------------------------------------------------
module time_triggered_task_dispatcher_unit_tb;
   import tttd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;

   logic clock;
   logic reset;
   logic start;
   req_type req_data;
   logic busy;
   logic rsp_valid;
   rsp_type rsp_data;
   int fail_count;
   int pending_count;
   int created_count;
   int stats_count;
   int idle_cycles;
   int sent_count;

   time_triggered_task_dispatcher_unit u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   time_triggered_task_dispatcher_unit_checker u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .created_count(created_count),
      .stats_count(stats_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_request(req_type rq);
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sent_count++;
   endtask

   task automatic random_gap();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic req_type noise_fields();
      req_type rq;
      rq.mode = ModeTick;
      rq.period_mask = 16'($urandom);
      rq.phase = 16'($urandom);
      rq.priority_req = 8'($urandom);
      rq.slice_number = 16'($urandom);
      rq.task_index = 3'($urandom);
      rq.run_status = 8'($urandom);
      rq.start_time = $urandom;
      rq.end_time = $urandom;
      return rq;
   endfunction

   function automatic req_type create_req(logic [15:0] m, logic [15:0] p, logic [7:0] pr);
      req_type rq;
      rq = noise_fields();
      rq.mode = ModeCreate;
      rq.period_mask = m;
      rq.phase = p;
      rq.priority_req = pr;
      return rq;
   endfunction

   function automatic req_type tick_req(logic [15:0] s);
      req_type rq;
      rq = noise_fields();
      rq.mode = ModeTick;
      rq.slice_number = s;
      return rq;
   endfunction

   function automatic req_type done_req(logic [2:0] t, logic [7:0] st, logic [31:0] a,
                                        logic [31:0] b);
      req_type rq;
      rq = noise_fields();
      rq.mode = ModeDone;
      rq.task_index = t;
      rq.run_status = st;
      rq.start_time = a;
      rq.end_time = b;
      return rq;
   endfunction

   function automatic req_type random_req(int unsigned tasks_made);
      req_type rq;
      int unsigned pick;
      logic [15:0] m;
      pick = $urandom_range(0, 99);
      if (pick < 15 || tasks_made == 0) begin
         m = ($urandom_range(0, 3) == 0) ? 16'(($urandom_range(0, 1)) ? 0 : 16'hFFFF)
                                           : 16'((1 << $urandom_range(0, 4)) - 1);
         rq = create_req(m, 16'($urandom) & m, ($urandom_range(0, 3) == 0) ?
                         8'($urandom_range(0, 2) * 127) : 8'($urandom));
      end else if (pick < 55) begin
         rq = tick_req(16'($urandom));
      end else if (pick < 95) begin
         rq = done_req(3'($urandom_range(0, 7)),
                       ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)),
                       $urandom, $urandom);
      end else begin
         rq = noise_fields();
         rq.mode = 2'd3;
      end
      return rq;
   endfunction

   initial begin
      int unsigned made;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      sent_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(tick_req(16'hFFFF));
      send_request(done_req(3'd0, 8'd0, 32'd0, 32'd5));
      send_request(create_req(16'd0, 16'd0, 8'd10));
      send_request(create_req(16'hFFFF, 16'hFFFF, 8'd255));
      send_request(create_req(16'd3, 16'd1, 8'd10));
      send_request(create_req(16'd1, 16'd0, 8'd0));
      send_request(tick_req(16'd0));
      send_request(tick_req(16'hFFFF));
      send_request(tick_req(16'd2));
      send_request(done_req(3'd0, 8'd1, 32'hFFFF_FFF0, 32'd16));
      send_request(done_req(3'd0, 8'd0, 32'd100, 32'd100));
      send_request(done_req(3'd1, 8'd2, 32'd0, 32'hFFFF_FFFF));
      send_request(done_req(3'd2, 8'd255, 32'hFFFF_FFFF, 32'd0));
      send_request(done_req(3'd7, 8'd0, 32'd1, 32'd2));
      send_request(tick_req(16'hFFFF));
      send_request(create_req(16'hAAAA, 16'h5555, 8'd128));
      send_request(create_req(16'h5555, 16'hAAAA, 8'd128));
      send_request(create_req(16'd7, 16'd7, 8'd1));
      send_request(create_req(16'd7, 16'd0, 8'd200));
      send_request(create_req(16'd1, 16'd1, 8'd5));
      send_request(create_req(16'd1, 16'd1, 8'd5));
      send_request(tick_req(16'd7));
      send_request(done_req(3'd7, 8'd0, 32'd0, 32'd3));
      begin
         req_type rq;
         rq = noise_fields();
         rq.mode = 2'd3;
         send_request(rq);
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);

      made = 8;
      repeat (160) begin
         random_gap();
         send_request(random_req(made));
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (3 * MaxTasks + 10) @(posedge clock);

      $display("Sent %0d requests; %0d tasks created, %0d done reports checked.",
               sent_count, created_count, stats_count);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
